// ===== rtl/slru_pkg.sv =====
// Package for the segmented LRU tag and replacement engine.
// Holds sizes, payload structs, entry layout and the controller/datapath codes.
// No dependencies.
package slru_pkg;

  localparam int unsigned SegmentSlots = 64;
  localparam int unsigned IdxW   = $clog2(SegmentSlots);
  localparam int unsigned NumW   = IdxW + 1;
  localparam int unsigned KeyW   = 64;
  localparam int unsigned LenW   = 32;
  localparam int unsigned BytesW = 40;
  localparam int unsigned CountW = 7;
  localparam int unsigned TotalW = 64;
  localparam int unsigned CapW   = 32;
  localparam int unsigned AddrW  = 3;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_PROB_CAP = 1'b0,
    REG_PROT_CAP = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic            cmd;
    logic [KeyW-1:0] block_key;
    logic [LenW-1:0] block_length;
  } item_t;

  typedef struct packed {
    logic              hit;
    logic              hit_was_protected;
    logic              inserted;
    logic [CountW-1:0] evicted_count;
    logic [CountW-1:0] demoted_count;
    logic [TotalW-1:0] hit_total;
    logic [TotalW-1:0] miss_total;
  } result_t;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [LenW-1:0] len;
  } entry_t;

  typedef enum logic {
    SEG_PROB = 1'b0,
    SEG_PROT = 1'b1
  } seg_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_JCLR,
    OP_SRCH_RD,
    OP_SRCH_NEXT,
    OP_SHR_RD,
    OP_SHR_WR,
    OP_SHL_RD,
    OP_SHL_WR,
    OP_WR_ITEM0,
    OP_PROB_DROP,
    OP_ADM_ITEM,
    OP_DEM_RD,
    OP_DEM_TAKE,
    OP_EVT_RD,
    OP_EVT_TAKE,
    OP_PROB_PUSH,
    OP_PROT_PUSH,
    OP_DONE
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    seg_e   seg;
    logic   hit;
    logic   hit_prot;
    logic   inserted;
  } ctrl_cmd_t;

  typedef struct packed {
    logic key_eq;
    logic len_eq;
    logic j_end;
    logic j_last;
    logic j_zero;
    logic dem_need;
    logic adm_need;
    logic put_ok;
    logic is_put;
  } dp_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SHR_RD,
    ST_SHR_WR,
    ST_SHL_RD,
    ST_SHL_WR,
    ST_DEM_CHK,
    ST_DEM_RD,
    ST_DEM_TAKE,
    ST_ADM_CHK,
    ST_EVT_RD,
    ST_EVT_TAKE,
    ST_DONE
  } ctrl_state_e;

endpackage

// ===== rtl/segmented_lru_cache_policy.sv =====
// Top level of the segmented LRU tag and replacement engine: APB capacity
// registers, controller and datapath. Depends on slru_pkg, slru_ctrl, slru_dp.
//
// A transaction is accepted when start is high and busy is low; its result
// appears on result_o for one cycle with done_o and cannot be held off. The
// engine works on one transaction at a time and all cost comes from the
// single read and write port of each segment memory: a search reads and
// compares each entry it examines, moving an entry inside a segment is a
// read and a write, each demotion is a read and a take followed by its push
// to probation, and each eviction is a read and a take. A get searches, on
// a hit shifts, and may then demote and evict; a put searches and, if it
// inserts, may evict first. busy drops in the same cycle in which the
// result appears. Each segment holds 64 entries.
module segmented_lru_cache_policy (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  slru_pkg::item_t             item_i,
  output logic                        done_o,
  output slru_pkg::result_t           result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [slru_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import slru_pkg::*;

  logic [CapW-1:0] prob_cap_q, prot_cap_q;
  reg_idx_e        reg_idx;
  ctrl_cmd_t       cmd;
  dp_status_t      status;

  assign reg_idx = reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prob_cap_q <= CapW'(6554);
      prot_cap_q <= CapW'(26214);
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_PROB_CAP: prob_cap_q <= pwdata;
        REG_PROT_CAP: prot_cap_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PROB_CAP: prdata = prob_cap_q;
      REG_PROT_CAP: prdata = prot_cap_q;
      default:      prdata = '0;
    endcase
  end

  slru_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .start_cmd_i (item_i.cmd),
    .busy_o      (busy),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  slru_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .prob_cap_i (prob_cap_q),
    .prot_cap_i (prot_cap_q),
    .cmd_i      (cmd),
    .status_o   (status),
    .done_o     (done_o),
    .result_o   (result_o)
  );

endmodule

// ===== rtl/slru_dp.sv =====
// Datapath of the segmented LRU engine: two segment memories kept as ring buffers,
// entry counts, byte totals, hit/miss counters and the result register.
// Depends on slru_pkg; driven by slru_ctrl through ctrl_cmd_t.
module slru_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  slru_pkg::item_t          item_i,
  input  logic [slru_pkg::CapW-1:0] prob_cap_i,
  input  logic [slru_pkg::CapW-1:0] prot_cap_i,
  input  slru_pkg::ctrl_cmd_t      cmd_i,
  output slru_pkg::dp_status_t     status_o,
  output logic                     done_o,
  output slru_pkg::result_t        result_o
);
  import slru_pkg::*;

  entry_t prob_mem [SegmentSlots];
  entry_t prot_mem [SegmentSlots];
  entry_t prob_rd_q, prot_rd_q;

  item_t             item_q, item_d;
  entry_t            adm_q, adm_d;
  logic [NumW-1:0]   j_q, j_d;
  logic [NumW-1:0]   prob_n_q, prob_n_d, prot_n_q, prot_n_d;
  logic [IdxW-1:0]   prob_base_q, prob_base_d, prot_base_q, prot_base_d;
  logic [BytesW-1:0] prob_bytes_q, prob_bytes_d, prot_bytes_q, prot_bytes_d;
  logic [CountW-1:0] evc_q, evc_d, dmc_q, dmc_d;
  logic [TotalW-1:0] hit_cnt_q, hit_cnt_d, miss_cnt_q, miss_cnt_d;
  result_t           result_q, result_d;
  logic              done_q, done_d;

  logic            rd_prob, rd_prot, we_prob, we_prot;
  logic [NumW-1:0] ra_log, wa_log;
  logic [IdxW-1:0] ra_prob, ra_prot, wa_prob, wa_prot;
  entry_t          wd;
  entry_t          item_ent, rd_sel;
  logic [NumW-1:0] n_sel;
  logic            use_prot;

  assign item_ent = '{key: item_q.block_key, len: item_q.block_length};
  assign use_prot = (cmd_i.seg == SEG_PROT);
  assign rd_sel   = use_prot ? prot_rd_q : prob_rd_q;
  assign n_sel    = use_prot ? prot_n_q : prob_n_q;

  always_comb begin
    item_d       = item_q;
    adm_d        = adm_q;
    j_d          = j_q;
    prob_n_d     = prob_n_q;
    prot_n_d     = prot_n_q;
    prob_base_d  = prob_base_q;
    prot_base_d  = prot_base_q;
    prob_bytes_d = prob_bytes_q;
    prot_bytes_d = prot_bytes_q;
    evc_d        = evc_q;
    dmc_d        = dmc_q;
    hit_cnt_d    = hit_cnt_q;
    miss_cnt_d   = miss_cnt_q;
    result_d     = result_q;
    done_d       = 1'b0;
    rd_prob      = 1'b0;
    rd_prot      = 1'b0;
    we_prob      = 1'b0;
    we_prot      = 1'b0;
    ra_log       = j_q;
    wa_log       = j_q;
    wd           = rd_sel;
    ra_prob      = prob_base_q + ra_log[IdxW-1:0];
    ra_prot      = prot_base_q + ra_log[IdxW-1:0];
    unique case (cmd_i.op)
      OP_LOAD: begin
        item_d = item_i;
        j_d    = '0;
        evc_d  = '0;
        dmc_d  = '0;
      end
      OP_JCLR:      j_d = '0;
      OP_SRCH_RD: begin
        rd_prob = !use_prot;
        rd_prot = use_prot;
      end
      OP_SRCH_NEXT: j_d = j_q + NumW'(1);
      OP_SHR_RD: begin
        ra_log  = j_q - NumW'(1);
        rd_prob = !use_prot;
        rd_prot = use_prot;
      end
      OP_SHR_WR: begin
        we_prob = !use_prot;
        we_prot = use_prot;
        j_d     = j_q - NumW'(1);
      end
      OP_SHL_RD: begin
        ra_log  = j_q + NumW'(1);
        rd_prob = !use_prot;
        rd_prot = use_prot;
      end
      OP_SHL_WR: begin
        we_prob = !use_prot;
        we_prot = use_prot;
        j_d     = j_q + NumW'(1);
      end
      OP_WR_ITEM0: begin
        wa_log  = '0;
        wd      = item_ent;
        we_prot = 1'b1;
      end
      OP_PROB_DROP: begin
        prob_n_d     = prob_n_q - NumW'(1);
        prob_bytes_d = prob_bytes_q - BytesW'(item_q.block_length);
      end
      OP_ADM_ITEM:  adm_d = item_ent;
      OP_DEM_RD: begin
        ra_log  = prot_n_q - NumW'(1);
        rd_prot = 1'b1;
      end
      OP_DEM_TAKE: begin
        adm_d        = prot_rd_q;
        prot_n_d     = prot_n_q - NumW'(1);
        prot_bytes_d = prot_bytes_q - BytesW'(prot_rd_q.len);
        if (dmc_q != '1) dmc_d = dmc_q + CountW'(1);
      end
      OP_EVT_RD: begin
        ra_log  = prob_n_q - NumW'(1);
        rd_prob = 1'b1;
      end
      OP_EVT_TAKE: begin
        prob_n_d     = prob_n_q - NumW'(1);
        prob_bytes_d = prob_bytes_q - BytesW'(prob_rd_q.len);
        if (evc_q != '1) evc_d = evc_q + CountW'(1);
      end
      OP_PROB_PUSH: begin
        prob_base_d  = prob_base_q - IdxW'(1);
        wa_log       = '0;
        wd           = adm_q;
        we_prob      = 1'b1;
        prob_n_d     = prob_n_q + NumW'(1);
        prob_bytes_d = prob_bytes_q + BytesW'(adm_q.len);
      end
      OP_PROT_PUSH: begin
        prot_base_d  = prot_base_q - IdxW'(1);
        wa_log       = '0;
        wd           = item_ent;
        we_prot      = 1'b1;
        prot_n_d     = prot_n_q + NumW'(1);
        prot_bytes_d = prot_bytes_q + BytesW'(item_q.block_length);
      end
      OP_DONE: begin
        if (item_q.cmd == CMD_GET) begin
          if (cmd_i.hit) hit_cnt_d = hit_cnt_q + TotalW'(1);
          else miss_cnt_d = miss_cnt_q + TotalW'(1);
        end
        result_d.hit               = cmd_i.hit;
        result_d.hit_was_protected = cmd_i.hit_prot;
        result_d.inserted          = cmd_i.inserted;
        result_d.evicted_count     = evc_q;
        result_d.demoted_count     = dmc_q;
        result_d.hit_total         = hit_cnt_d;
        result_d.miss_total        = miss_cnt_d;
        done_d                     = 1'b1;
      end
      default: ;
    endcase
    ra_prob = prob_base_q + ra_log[IdxW-1:0];
    ra_prot = prot_base_q + ra_log[IdxW-1:0];
    wa_prob = prob_base_d + wa_log[IdxW-1:0];
    wa_prot = prot_base_d + wa_log[IdxW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (we_prob) prob_mem[wa_prob] <= wd;
    if (rd_prob) prob_rd_q <= prob_mem[ra_prob];
  end

  always_ff @(posedge clk_i) begin
    if (we_prot) prot_mem[wa_prot] <= wd;
    if (rd_prot) prot_rd_q <= prot_mem[ra_prot];
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    adm_q    <= adm_d;
    evc_q    <= evc_d;
    dmc_q    <= dmc_d;
    result_q <= result_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q          <= '0;
      prob_n_q     <= '0;
      prot_n_q     <= '0;
      prob_base_q  <= '0;
      prot_base_q  <= '0;
      prob_bytes_q <= '0;
      prot_bytes_q <= '0;
      hit_cnt_q    <= '0;
      miss_cnt_q   <= '0;
      done_q       <= 1'b0;
    end else begin
      j_q          <= j_d;
      prob_n_q     <= prob_n_d;
      prot_n_q     <= prot_n_d;
      prob_base_q  <= prob_base_d;
      prot_base_q  <= prot_base_d;
      prob_bytes_q <= prob_bytes_d;
      prot_bytes_q <= prot_bytes_d;
      hit_cnt_q    <= hit_cnt_d;
      miss_cnt_q   <= miss_cnt_d;
      done_q       <= done_d;
    end
  end

  always_comb begin
    status_o.key_eq   = (rd_sel.key == item_q.block_key);
    status_o.len_eq   = (rd_sel.len == item_q.block_length);
    status_o.j_end    = (j_q >= n_sel);
    status_o.j_last   = ((j_q + NumW'(1)) >= n_sel);
    status_o.j_zero   = (j_q == '0);
    status_o.dem_need = (((prot_bytes_q + BytesW'(item_q.block_length)) > BytesW'(prot_cap_i))
                         || (prot_n_q == NumW'(SegmentSlots))) && (prot_n_q != '0);
    status_o.adm_need = (((prob_bytes_q + BytesW'(adm_q.len)) > BytesW'(prob_cap_i))
                         && (prob_n_q != '0)) || (prob_n_q == NumW'(SegmentSlots));
    status_o.put_ok   = (item_q.block_length != '0) && (item_q.block_length <= prob_cap_i);
    status_o.is_put   = (item_q.cmd == CMD_PUT);
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ===== rtl/slru_ctrl.sv =====
// Controller of the segmented LRU engine: sequences search, shift, demote,
// evict and push steps of one transaction. Depends on slru_pkg.
module slru_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  start_cmd_i,
  output logic                  busy_o,
  input  slru_pkg::dp_status_t  status_i,
  output slru_pkg::ctrl_cmd_t   cmd_o
);
  import slru_pkg::*;

  ctrl_state_e state_q, state_d;
  seg_e        seg_q, seg_d;
  logic        hit_q, hit_d, hitp_q, hitp_d, ins_q, ins_d;
  dp_op_e      op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seg_q   <= SEG_PROB;
      hit_q   <= 1'b0;
      hitp_q  <= 1'b0;
      ins_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      seg_q   <= seg_d;
      hit_q   <= hit_d;
      hitp_q  <= hitp_d;
      ins_q   <= ins_d;
    end
  end

  always_comb begin
    state_d = state_q;
    seg_d   = seg_q;
    hit_d   = hit_q;
    hitp_d  = hitp_q;
    ins_d   = ins_q;
    op      = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op      = OP_LOAD;
          seg_d   = (start_cmd_i == CMD_PUT) ? SEG_PROB : SEG_PROT;
          hit_d   = 1'b0;
          hitp_d  = 1'b0;
          ins_d   = 1'b0;
          state_d = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        if (status_i.is_put && !status_i.put_ok) begin
          state_d = ST_DONE;
        end else if (status_i.j_end) begin
          // key not in this segment
          if ((seg_q == SEG_PROT) != status_i.is_put) begin
            op    = OP_JCLR;
            seg_d = status_i.is_put ? SEG_PROT : SEG_PROB;
          end else if (status_i.is_put) begin
            op      = OP_ADM_ITEM;
            state_d = ST_ADM_CHK;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          op      = OP_SRCH_RD;
          state_d = ST_SRCH_CMP;
        end
      end
      ST_SRCH_CMP: begin
        if (!status_i.key_eq) begin
          op      = OP_SRCH_NEXT;
          state_d = ST_SRCH_RD;
        end else if (status_i.is_put) begin
          state_d = ST_DONE;
        end else if (seg_q == SEG_PROT) begin
          if (status_i.len_eq) begin
            hit_d   = 1'b1;
            hitp_d  = 1'b1;
            state_d = ST_SHR_RD;
          end else begin
            // length mismatch: fall through to probation
            op      = OP_JCLR;
            seg_d   = SEG_PROB;
            state_d = ST_SRCH_RD;
          end
        end else if (status_i.len_eq) begin
          hit_d   = 1'b1;
          state_d = ST_SHL_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SHR_RD: begin
        if (status_i.j_zero) begin
          op      = OP_WR_ITEM0;
          state_d = ST_DONE;
        end else begin
          op      = OP_SHR_RD;
          state_d = ST_SHR_WR;
        end
      end
      ST_SHR_WR: begin
        op      = OP_SHR_WR;
        state_d = ST_SHR_RD;
      end
      ST_SHL_RD: begin
        if (status_i.j_last) begin
          op      = OP_PROB_DROP;
          state_d = ST_DEM_CHK;
        end else begin
          op      = OP_SHL_RD;
          state_d = ST_SHL_WR;
        end
      end
      ST_SHL_WR: begin
        op      = OP_SHL_WR;
        state_d = ST_SHL_RD;
      end
      ST_DEM_CHK: begin
        if (status_i.dem_need) begin
          op      = OP_DEM_RD;
          state_d = ST_DEM_TAKE;
        end else begin
          op      = OP_PROT_PUSH;
          state_d = ST_DONE;
        end
      end
      ST_DEM_RD: begin
        op      = OP_DEM_RD;
        state_d = ST_DEM_TAKE;
      end
      ST_DEM_TAKE: begin
        op      = OP_DEM_TAKE;
        state_d = ST_ADM_CHK;
      end
      ST_ADM_CHK: begin
        if (status_i.adm_need) begin
          op      = OP_EVT_RD;
          state_d = ST_EVT_TAKE;
        end else begin
          op = OP_PROB_PUSH;
          if (status_i.is_put) begin
            ins_d   = 1'b1;
            state_d = ST_DONE;
          end else begin
            state_d = ST_DEM_CHK;
          end
        end
      end
      ST_EVT_RD: begin
        op      = OP_EVT_RD;
        state_d = ST_EVT_TAKE;
      end
      ST_EVT_TAKE: begin
        op      = OP_EVT_TAKE;
        state_d = ST_ADM_CHK;
      end
      ST_DONE: begin
        op      = OP_DONE;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);
  assign cmd_o  = '{op: op, seg: seg_q, hit: hit_q, hit_prot: hitp_q, inserted: ins_q};

endmodule

// ===== rtl/slru_checker.sv =====
// Port-level checker for segmented_lru_cache_policy, attached by bind.
// Depends on slru_pkg.
module slru_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input slru_pkg::result_t result_o
);
  import slru_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted transaction did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result shown while still busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe lasted two cycles");

  a_prot_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.hit_was_protected |-> result_o.hit)
    else $error("protected flag without hit");

  a_ins_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.inserted |-> !result_o.hit && (result_o.demoted_count == '0))
    else $error("insert reported hit or demotion");

endmodule

bind segmented_lru_cache_policy slru_checker u_slru_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);
